### hw/rtl/der_pkg.sv
// Shared types and constants for the elevator disk request scheduler.
// No dependencies.
`default_nettype none
package der_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int BLOCK_SHIFT_DEF = 9;

  localparam int TAG_W   = 8;
  localparam int BLK_W   = 21;
  localparam int CNT_W   = 16;
  localparam int UNIT_W  = 3;
  localparam int ADDR_W  = 24;
  localparam int ERR_W   = 7;
  localparam int RETRY_W = 4;
  localparam int CHUNK_W = 9;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd3;
  localparam logic [CHUNK_W-1:0] MAX_CHUNK_RST   = 9'd256;
  localparam logic [CHUNK_W-1:0] CHUNK_CAP       = 9'd256;
  localparam logic [RETRY_W-1:0] RETRY_SAT       = 4'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK   = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_CMD   = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_UNEXP = 2'd2,
    KIND_REJ   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [BLK_W-1:0]  blk;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  rem;
    logic              rd;
    logic [UNIT_W-1:0] unit;
    logic [ADDR_W-1:0] base;
  } ent_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ALLOC_FRESH,
    OP_POP_RD,
    OP_POP_TAKE,
    OP_WRITE_ENT,
    OP_WALK_RD,
    OP_WALK_STEP,
    OP_LINK_HEAD,
    OP_LINK_RD,
    OP_LINK_TAKE,
    OP_SPLICE_A,
    OP_SPLICE_B,
    OP_ENT_RD,
    OP_ISSUE,
    OP_CLR_BUSY,
    OP_C_RD,
    OP_CUPD,
    OP_REM_RD,
    OP_REM_LINK,
    OP_EMIT_DONE,
    OP_EMIT_REJ,
    OP_EMIT_UNEXP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic opc;
    logic busy;
    logic cur_head;
    logic full;
    logic fresh_ok;
    logic x_head;
    logic blk_lt;
    logic go_rem;
    logic slot_free;
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DEC,
    ST_POP,
    ST_WRITE,
    ST_WALK,
    ST_WCMP,
    ST_LINK,
    ST_LBWD,
    ST_SPLICE,
    ST_SPLICE2,
    ST_ISSUE,
    ST_ISSUE2,
    ST_CUPD,
    ST_REM,
    ST_RLINK,
    ST_RDONE,
    ST_REJ,
    ST_UNEXP
  } st_t;

endpackage
`default_nettype wire

### hw/rtl/disk_elevator_request_scheduler.sv
// Top level of the elevator (SCAN) disk request scheduler.
// Depends on der_pkg, der_ctrl, der_dp and der_ram.
//
// Requests live in a table linked in descending block order; one item is
// handled at a time. The sorted position of an insert is found by following
// forward links through a RAM with registered read data. A result waits in
// an output register and stalls the sequencer only when a further result is
// due. Configuration is accepted every cycle. No clearing pass is needed
// after reset.
`default_nettype none
module disk_elevator_request_scheduler #(
  parameter int QUEUE_DEPTH = der_pkg::QUEUE_DEPTH_DEF,
  parameter int BLOCK_SHIFT = der_pkg::BLOCK_SHIFT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_opcode,
  input  wire logic [der_pkg::TAG_W-1:0]      in_request_tag,
  input  wire logic [der_pkg::BLK_W-1:0]      in_start_block,
  input  wire logic [der_pkg::CNT_W-1:0]      in_block_count,
  input  wire logic                           in_is_read,
  input  wire logic [der_pkg::UNIT_W-1:0]     in_unit,
  input  wire logic [der_pkg::ADDR_W-1:0]     in_buffer_address,
  input  wire logic [der_pkg::ERR_W-1:0]      in_err_code,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [der_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [der_pkg::CHUNK_W-1:0]    cfg_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [der_pkg::KIND_W-1:0]          out_kind,
  output logic [der_pkg::TAG_W-1:0]           out_out_tag,
  output logic [der_pkg::BLK_W-1:0]           out_cmd_block,
  output logic [der_pkg::CHUNK_W-1:0]         out_cmd_count,
  output logic                                out_cmd_read,
  output logic [der_pkg::UNIT_W-1:0]          out_cmd_unit,
  output logic [der_pkg::ADDR_W-1:0]          out_cmd_address,
  output logic                                out_failed,
  output logic                                out_last
);
  import der_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  der_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .stat, .cmd
  );

  der_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .BLOCK_SHIFT(BLOCK_SHIFT)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_opcode, .in_request_tag, .in_start_block, .in_block_count,
    .in_is_read, .in_unit, .in_buffer_address, .in_err_code,
    .cfg_valid, .cfg_index, .cfg_data,
    .out_valid, .out_ready, .out_kind, .out_out_tag, .out_cmd_block,
    .out_cmd_count, .out_cmd_read, .out_cmd_unit, .out_cmd_address,
    .out_failed, .out_last
  );
endmodule
`default_nettype wire

### hw/rtl/der_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module der_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

### hw/rtl/der_ctrl.sv
// Sequencer for the scheduler: walks insert, completion, issue and removal steps.
// Depends on der_pkg.
`default_nettype none
module der_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire der_pkg::dp_stat_t stat,
  output der_pkg::dp_cmd_t       cmd
);
  import der_pkg::*;

  st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        if (stat.opc) begin
          if (!stat.busy) begin
            state_nxt = ST_UNEXP;
          end else if (stat.cur_head) begin
            cmd.op    = OP_CLR_BUSY;
            state_nxt = ST_ISSUE;
          end else begin
            cmd.op    = OP_C_RD;
            state_nxt = ST_CUPD;
          end
        end else if (stat.full) begin
          state_nxt = ST_REJ;
        end else if (stat.fresh_ok) begin
          cmd.op    = OP_ALLOC_FRESH;
          state_nxt = ST_WRITE;
        end else begin
          cmd.op    = OP_POP_RD;
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        cmd.op    = OP_POP_TAKE;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.op    = OP_WRITE_ENT;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (stat.x_head) begin
          state_nxt = ST_LINK;
        end else begin
          cmd.op    = OP_WALK_RD;
          state_nxt = ST_WCMP;
        end
      end
      ST_WCMP: begin
        if (stat.blk_lt) begin
          cmd.op    = OP_WALK_STEP;
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_LINK;
        end
      end
      ST_LINK: begin
        if (stat.x_head) begin
          cmd.op    = OP_LINK_HEAD;
          state_nxt = ST_SPLICE;
        end else begin
          cmd.op    = OP_LINK_RD;
          state_nxt = ST_LBWD;
        end
      end
      ST_LBWD: begin
        cmd.op    = OP_LINK_TAKE;
        state_nxt = ST_SPLICE;
      end
      ST_SPLICE: begin
        cmd.op    = OP_SPLICE_A;
        state_nxt = ST_SPLICE2;
      end
      ST_SPLICE2: begin
        cmd.op    = OP_SPLICE_B;
        state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (stat.busy || stat.cur_head) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.op    = OP_ENT_RD;
          state_nxt = ST_ISSUE2;
        end
      end
      ST_ISSUE2: begin
        if (stat.slot_free) begin
          cmd.op    = OP_ISSUE;
          state_nxt = ST_IDLE;
        end
      end
      ST_CUPD: begin
        cmd.op    = OP_CUPD;
        state_nxt = stat.go_rem ? ST_REM : ST_ISSUE;
      end
      ST_REM: begin
        cmd.op    = OP_REM_RD;
        state_nxt = ST_RLINK;
      end
      ST_RLINK: begin
        cmd.op    = OP_REM_LINK;
        state_nxt = ST_RDONE;
      end
      ST_RDONE: begin
        if (stat.slot_free) begin
          cmd.op    = OP_EMIT_DONE;
          state_nxt = ST_ISSUE;
        end
      end
      ST_REJ: begin
        if (stat.slot_free) begin
          cmd.op    = OP_EMIT_REJ;
          state_nxt = ST_IDLE;
        end
      end
      ST_UNEXP: begin
        if (stat.slot_free) begin
          cmd.op    = OP_EMIT_UNEXP;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

### hw/rtl/der_dp.sv
// Datapath: request table, link RAMs, free stack, sweep state and result register.
// Depends on der_pkg and der_ram.
`default_nettype none
module der_dp #(
  parameter int QUEUE_DEPTH = der_pkg::QUEUE_DEPTH_DEF,
  parameter int BLOCK_SHIFT = der_pkg::BLOCK_SHIFT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire der_pkg::dp_cmd_t               cmd,
  output der_pkg::dp_stat_t                   stat,
  input  wire logic                           in_opcode,
  input  wire logic [der_pkg::TAG_W-1:0]      in_request_tag,
  input  wire logic [der_pkg::BLK_W-1:0]      in_start_block,
  input  wire logic [der_pkg::CNT_W-1:0]      in_block_count,
  input  wire logic                           in_is_read,
  input  wire logic [der_pkg::UNIT_W-1:0]     in_unit,
  input  wire logic [der_pkg::ADDR_W-1:0]     in_buffer_address,
  input  wire logic [der_pkg::ERR_W-1:0]      in_err_code,
  input  wire logic                           cfg_valid,
  input  wire logic [der_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [der_pkg::CHUNK_W-1:0]    cfg_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [der_pkg::KIND_W-1:0]          out_kind,
  output logic [der_pkg::TAG_W-1:0]           out_out_tag,
  output logic [der_pkg::BLK_W-1:0]           out_cmd_block,
  output logic [der_pkg::CHUNK_W-1:0]         out_cmd_count,
  output logic                                out_cmd_read,
  output logic [der_pkg::UNIT_W-1:0]          out_cmd_unit,
  output logic [der_pkg::ADDR_W-1:0]          out_cmd_address,
  output logic                                out_failed,
  output logic                                out_last
);
  import der_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $bits(ent_t);
  localparam logic [LW-1:0] HEAD = LW'(QUEUE_DEPTH);

  // latched input beat
  logic              opc_r;
  logic [TAG_W-1:0]  tag_r;
  logic [BLK_W-1:0]  blk_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              rd_r;
  logic [UNIT_W-1:0] unit_r;
  logic [ADDR_W-1:0] base_r;
  logic [ERR_W-1:0]  err_r;

  logic [RETRY_W-1:0] retry_limit_r;
  logic [CHUNK_W-1:0] max_chunk_r;

  logic [LW-1:0] cur_r, head_f_r, head_b_r, x_r, p_r, fresh_r, sp_r;
  logic [IW-1:0] e_r;
  logic          dir_r, busy_r, fail_r;
  logic [RETRY_W-1:0] retry_r;

  logic              out_valid_r;
  logic [KIND_W-1:0] kind_r;
  logic [TAG_W-1:0]  otag_r;
  logic [BLK_W-1:0]  oblk_r;
  logic [CHUNK_W-1:0] ocnt_r;
  logic              ord_r;
  logic [UNIT_W-1:0] ounit_r;
  logic [ADDR_W-1:0] oaddr_r;
  logic              ofail_r;
  logic              olast_r;

  // RAM ports
  logic          ent_we, ent_re, fwd_we, fwd_re, bwd_we, bwd_re, stk_we, stk_re;
  logic [IW-1:0] ent_wa, ent_ra, fwd_wa, fwd_ra, bwd_wa, bwd_ra, stk_wa, stk_ra;
  ent_t          ent_wd;
  logic [EW-1:0] ent_rd_raw;
  ent_t          ent_rd;
  logic [LW-1:0] fwd_wd, fwd_rd, bwd_wd, bwd_rd;
  logic [IW-1:0] stk_wd, stk_rd;

  der_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ent (
    .clk, .we(ent_we), .waddr(ent_wa), .wdata(ent_wd),
    .re(ent_re), .raddr(ent_ra), .rdata(ent_rd_raw)
  );
  der_ram #(.WIDTH(LW), .DEPTH(QUEUE_DEPTH)) u_fwd (
    .clk, .we(fwd_we), .waddr(fwd_wa), .wdata(fwd_wd),
    .re(fwd_re), .raddr(fwd_ra), .rdata(fwd_rd)
  );
  der_ram #(.WIDTH(LW), .DEPTH(QUEUE_DEPTH)) u_bwd (
    .clk, .we(bwd_we), .waddr(bwd_wa), .wdata(bwd_wd),
    .re(bwd_re), .raddr(bwd_ra), .rdata(bwd_rd)
  );
  der_ram #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_stk (
    .clk, .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
    .re(stk_re), .raddr(stk_ra), .rdata(stk_rd)
  );

  assign ent_rd = ent_t'(ent_rd_raw);

  // chunk arithmetic
  logic [CHUNK_W-1:0] lim, chunk;
  logic [CNT_W-1:0]   done_cnt, rem_new;
  logic [RETRY_W-1:0] retry_inc;
  logic               go_rem;
  logic [LW-1:0]      rem_f, rem_b, step1, step2;
  logic               slot_free;
  logic               emit;

  always_comb begin
    if (max_chunk_r == '0) begin
      lim = CHUNK_W'(1);
    end else if (max_chunk_r > CHUNK_CAP) begin
      lim = CHUNK_CAP;
    end else begin
      lim = max_chunk_r;
    end
    chunk     = (ent_rd.rem > CNT_W'(lim)) ? lim : ent_rd.rem[CHUNK_W-1:0];
    done_cnt  = ent_rd.total - ent_rd.rem;
    rem_new   = ent_rd.rem - CNT_W'(chunk);
    retry_inc = (retry_r < RETRY_SAT) ? retry_r + RETRY_W'(1) : retry_r;
    go_rem    = (err_r == '0) ? (rem_new == '0) : (retry_inc >= retry_limit_r);
    rem_f     = fwd_rd;
    rem_b     = bwd_rd;
    step1     = dir_r ? rem_f : rem_b;
    step2     = dir_r ? rem_b : rem_f;
  end

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = (cmd.op == OP_ISSUE) || (cmd.op == OP_EMIT_DONE) ||
                     (cmd.op == OP_EMIT_REJ) || (cmd.op == OP_EMIT_UNEXP);

  always_comb begin
    stat.opc       = opc_r;
    stat.busy      = busy_r;
    stat.cur_head  = (cur_r == HEAD);
    stat.fresh_ok  = (fresh_r != HEAD);
    stat.full      = (fresh_r == HEAD) && (sp_r == '0);
    stat.x_head    = (x_r == HEAD);
    stat.blk_lt    = blk_r < ent_rd.blk;
    stat.go_rem    = go_rem;
    stat.slot_free = slot_free;
  end

  // RAM control
  always_comb begin
    ent_we = 1'b0; ent_re = 1'b0; fwd_we = 1'b0; fwd_re = 1'b0;
    bwd_we = 1'b0; bwd_re = 1'b0; stk_we = 1'b0; stk_re = 1'b0;
    ent_wa = e_r; ent_ra = cur_r[IW-1:0];
    fwd_wa = e_r; fwd_ra = x_r[IW-1:0];
    bwd_wa = e_r; bwd_ra = x_r[IW-1:0];
    stk_wa = sp_r[IW-1:0]; stk_ra = IW'(sp_r - LW'(1));
    stk_wd = cur_r[IW-1:0];
    fwd_wd = x_r; bwd_wd = p_r;
    ent_wd.tag   = tag_r;
    ent_wd.blk   = blk_r;
    ent_wd.total = cnt_r;
    ent_wd.rem   = cnt_r;
    ent_wd.rd    = rd_r;
    ent_wd.unit  = unit_r;
    ent_wd.base  = base_r;
    case (cmd.op)
      OP_POP_RD:    stk_re = 1'b1;
      OP_WRITE_ENT: ent_we = 1'b1;
      OP_WALK_RD: begin
        ent_re = 1'b1;
        ent_ra = x_r[IW-1:0];
        fwd_re = 1'b1;
      end
      OP_LINK_RD:   bwd_re = 1'b1;
      OP_SPLICE_A: begin
        fwd_we = 1'b1;
        bwd_we = 1'b1;
      end
      OP_SPLICE_B: begin
        fwd_we = (p_r != HEAD);
        fwd_wa = p_r[IW-1:0];
        fwd_wd = LW'(e_r);
        bwd_we = (x_r != HEAD);
        bwd_wa = x_r[IW-1:0];
        bwd_wd = LW'(e_r);
      end
      OP_ENT_RD, OP_C_RD: ent_re = 1'b1;
      OP_CUPD: begin
        if (err_r == '0) begin
          ent_we     = 1'b1;
          ent_wa     = cur_r[IW-1:0];
          ent_wd     = ent_rd;
          ent_wd.rem = rem_new;
        end
      end
      OP_REM_RD: begin
        fwd_re = 1'b1;
        fwd_ra = cur_r[IW-1:0];
        bwd_re = 1'b1;
        bwd_ra = cur_r[IW-1:0];
      end
      OP_REM_LINK: begin
        fwd_we = (rem_b != HEAD);
        fwd_wa = rem_b[IW-1:0];
        fwd_wd = rem_f;
        bwd_we = (rem_f != HEAD);
        bwd_wa = rem_f[IW-1:0];
        bwd_wd = rem_b;
        stk_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= RETRY_LIMIT_RST;
      max_chunk_r   <= MAX_CHUNK_RST;
      cur_r         <= HEAD;
      head_f_r      <= HEAD;
      head_b_r      <= HEAD;
      fresh_r       <= '0;
      sp_r          <= '0;
      dir_r         <= 1'b1;
      busy_r        <= 1'b0;
      retry_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_RETRY_LIMIT: retry_limit_r <= cfg_data[RETRY_W-1:0];
          CFG_MAX_CHUNK:   max_chunk_r   <= cfg_data;
          default: begin
          end
        endcase
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_ALLOC_FRESH: fresh_r <= fresh_r + LW'(1);
        OP_POP_RD:      sp_r <= sp_r - LW'(1);
        OP_WRITE_ENT:   retry_r <= '0;
        OP_SPLICE_B: begin
          if (p_r == HEAD) begin
            head_f_r <= LW'(e_r);
          end
          if (x_r == HEAD) begin
            head_b_r <= LW'(e_r);
          end
          if (cur_r == HEAD) begin
            cur_r <= LW'(e_r);
          end
        end
        OP_CLR_BUSY, OP_C_RD: busy_r <= 1'b0;
        OP_CUPD: begin
          if (err_r != '0) begin
            retry_r <= retry_inc;
          end
        end
        OP_REM_LINK: begin
          if (rem_b == HEAD) begin
            head_f_r <= rem_f;
          end
          if (rem_f == HEAD) begin
            head_b_r <= rem_b;
          end
          sp_r <= sp_r + LW'(1);
          // end of list reverses the sweep
          if (step1 == HEAD) begin
            dir_r <= !dir_r;
            cur_r <= step2;
          end else begin
            cur_r <= step1;
          end
        end
        OP_ISSUE: busy_r <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        opc_r  <= in_opcode;
        tag_r  <= in_request_tag;
        blk_r  <= in_start_block;
        cnt_r  <= in_block_count;
        rd_r   <= in_is_read;
        unit_r <= in_unit;
        base_r <= in_buffer_address;
        err_r  <= in_err_code;
      end
      OP_ALLOC_FRESH: e_r <= fresh_r[IW-1:0];
      OP_POP_TAKE:    e_r <= stk_rd;
      OP_WRITE_ENT:   x_r <= head_f_r;
      OP_WALK_STEP:   x_r <= fwd_rd;
      OP_LINK_HEAD:   p_r <= head_b_r;
      OP_LINK_TAKE:   p_r <= bwd_rd;
      OP_CUPD:        fail_r <= (err_r != '0);
      OP_ISSUE: begin
        kind_r  <= KIND_CMD;
        otag_r  <= ent_rd.tag;
        oblk_r  <= ent_rd.blk + BLK_W'(done_cnt);
        ocnt_r  <= chunk;
        ord_r   <= ent_rd.rd;
        ounit_r <= ent_rd.unit;
        oaddr_r <= ent_rd.base + (ADDR_W'(done_cnt) << BLOCK_SHIFT);
        ofail_r <= 1'b0;
        olast_r <= 1'b1;
      end
      OP_EMIT_DONE, OP_EMIT_REJ, OP_EMIT_UNEXP: begin
        oblk_r  <= '0;
        ocnt_r  <= '0;
        ord_r   <= 1'b0;
        ounit_r <= '0;
        oaddr_r <= '0;
        if (cmd.op == OP_EMIT_DONE) begin
          kind_r  <= KIND_DONE;
          otag_r  <= ent_rd.tag;
          ofail_r <= fail_r;
          olast_r <= (cur_r == HEAD);  // a command follows unless the list emptied
        end else if (cmd.op == OP_EMIT_REJ) begin
          kind_r  <= KIND_REJ;
          otag_r  <= tag_r;
          ofail_r <= 1'b0;
          olast_r <= 1'b1;
        end else begin
          kind_r  <= KIND_UNEXP;
          otag_r  <= '0;
          ofail_r <= 1'b0;
          olast_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_out_tag     = otag_r;
  assign out_cmd_block   = oblk_r;
  assign out_cmd_count   = ocnt_r;
  assign out_cmd_read    = ord_r;
  assign out_cmd_unit    = ounit_r;
  assign out_cmd_address = oaddr_r;
  assign out_failed      = ofail_r;
  assign out_last        = olast_r;
endmodule
`default_nettype wire

### dv/disk_elevator_request_scheduler_tb.sv
// Testbench for disk_elevator_request_scheduler: directed and random insert and
// completion beats checked against a cycle-free scheduler predictor.
// Depends on der_pkg and the scheduler RTL.
`timescale 1ns / 1ps
module disk_elevator_request_scheduler_tb;
  import der_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int HEAD  = DEPTH;
  localparam logic OPC_INSERT   = 1'b0;
  localparam logic OPC_COMPLETE = 1'b1;

  typedef struct {
    kind_t              kind;
    logic [TAG_W-1:0]   tag;
    logic [BLK_W-1:0]   blk;
    logic [CHUNK_W-1:0] cnt;
    logic               rd;
    logic [UNIT_W-1:0]  unit;
    logic [ADDR_W-1:0]  addr;
    logic               failed;
    logic               last;
  } sched_result_t;

  class elevator_scoreboard;
    logic [BLK_W-1:0]   blk_tbl[DEPTH];
    logic [CNT_W-1:0]   total_tbl[DEPTH];
    logic [CNT_W-1:0]   rem_tbl[DEPTH];
    logic               rd_tbl[DEPTH];
    logic [UNIT_W-1:0]  unit_tbl[DEPTH];
    logic [TAG_W-1:0]   tag_tbl[DEPTH];
    logic [ADDR_W-1:0]  base_tbl[DEPTH];
    int                 fwd[DEPTH+1];
    int                 bwd[DEPTH+1];
    bit                 free_slot[DEPTH];
    int                 cur;
    bit                 sweep_fwd;
    bit                 busy;
    logic [RETRY_W-1:0] retries;
    logic [RETRY_W-1:0] retry_limit;
    logic [CHUNK_W-1:0] max_chunk;
    sched_result_t      pending_results[$];
    int                 errors, checked, rejects, unexpected, failures;

    function new();
      for (int i = 0; i <= DEPTH; i++) begin
        fwd[i] = HEAD;
        bwd[i] = HEAD;
      end
      for (int i = 0; i < DEPTH; i++) free_slot[i] = 1;
      cur = HEAD;
      sweep_fwd = 1;
      busy = 0;
      retries = 0;
      retry_limit = RETRY_LIMIT_RST;
      max_chunk = MAX_CHUNK_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CHUNK_W-1:0] data);
      if (idx == CFG_RETRY_LIMIT) retry_limit = data[RETRY_W-1:0];
      else max_chunk = data;
    endfunction

    function int chunk_of(int remaining);
      int lim;
      lim = (max_chunk == 0) ? 1 : (max_chunk > 256) ? 256 : max_chunk;
      return (remaining > lim) ? lim : remaining;
    endfunction

    function int next_in_sweep(int e);
      return sweep_fwd ? fwd[e] : bwd[e];
    endfunction

    function void push(kind_t kind, logic [TAG_W-1:0] tag, logic [BLK_W-1:0] blk,
                       logic [CHUNK_W-1:0] cnt, logic rd, logic [UNIT_W-1:0] unit,
                       logic [ADDR_W-1:0] addr, logic failed);
      sched_result_t r;
      r.kind = kind; r.tag = tag; r.blk = blk; r.cnt = cnt; r.rd = rd;
      r.unit = unit; r.addr = addr; r.failed = failed; r.last = 0;
      pending_results.push_back(r);
    endfunction

    function void retire_current();
      int e;
      e = cur;
      bwd[fwd[e]] = bwd[e];
      fwd[bwd[e]] = fwd[e];
      free_slot[e] = 1;
      cur = next_in_sweep(e);
      if (cur == HEAD) begin
        sweep_fwd = !sweep_fwd;
        cur = next_in_sweep(e);
      end
    endfunction

    function void issue_if_idle();
      logic [CNT_W-1:0] done;
      if (busy || cur == HEAD) return;
      busy = 1;
      done = total_tbl[cur] - rem_tbl[cur];
      push(KIND_CMD, tag_tbl[cur], blk_tbl[cur] + BLK_W'(done),
           CHUNK_W'(chunk_of(rem_tbl[cur])), rd_tbl[cur], unit_tbl[cur],
           base_tbl[cur] + (ADDR_W'(done) << BLOCK_SHIFT_DEF), 1'b0);
    endfunction

    // Works out the results one accepted input beat causes.
    function void accept_request(logic opc, logic [TAG_W-1:0] tag, logic [BLK_W-1:0] blk,
                                 logic [CNT_W-1:0] cnt, logic rd, logic [UNIT_W-1:0] unit,
                                 logic [ADDR_W-1:0] addr, logic [ERR_W-1:0] err);
      int n0, e, x, n;
      n0 = pending_results.size();
      if (opc == OPC_INSERT) begin
        e = -1;
        for (int i = DEPTH - 1; i >= 0; i--) if (free_slot[i]) e = i;
        if (e < 0) begin
          push(KIND_REJ, tag, 0, 0, 0, 0, 0, 0);
          rejects++;
        end else begin
          free_slot[e] = 0;
          blk_tbl[e] = blk; total_tbl[e] = cnt; rem_tbl[e] = cnt; rd_tbl[e] = rd;
          unit_tbl[e] = unit; tag_tbl[e] = tag; base_tbl[e] = addr;
          retries = 0;
          x = fwd[HEAD];
          while (x != HEAD && blk < blk_tbl[x]) x = fwd[x];
          fwd[e] = x;
          bwd[e] = bwd[x];
          fwd[bwd[x]] = e;
          bwd[x] = e;
          if (cur == HEAD) cur = e;
          issue_if_idle();
        end
      end else if (!busy) begin
        push(KIND_UNEXP, 0, 0, 0, 0, 0, 0, 0);
        unexpected++;
      end else begin
        busy = 0;
        if (cur != HEAD) begin
          if (err == 0) begin
            n = chunk_of(rem_tbl[cur]);
            rem_tbl[cur] -= CNT_W'(n);
            if (rem_tbl[cur] == 0) begin
              push(KIND_DONE, tag_tbl[cur], 0, 0, 0, 0, 0, 0);
              retire_current();
            end
          end else begin
            if (retries != RETRY_SAT) retries++;
            if (retries >= retry_limit) begin
              push(KIND_DONE, tag_tbl[cur], 0, 0, 0, 0, 0, 1'b1);
              failures++;
              retire_current();
            end
          end
        end
        issue_if_idle();
      end
      if (pending_results.size() > n0) pending_results[pending_results.size()-1].last = 1;
    endfunction

    function void check_result(sched_result_t act);
      sched_result_t exp;
      checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: kind %0d tag %0d",
                 $time, act.kind, act.tag);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (act != exp) begin
        $display("%0t: mismatch exp kind %0d tag %0d blk %0d cnt %0d rd %0d unit %0d",
                 $time, exp.kind, exp.tag, exp.blk, exp.cnt, exp.rd, exp.unit);
        $display("  addr %0h failed %0d last %0d | act kind %0d tag %0d blk %0d cnt %0d",
                 exp.addr, exp.failed, exp.last, act.kind, act.tag, act.blk, act.cnt);
        $display("  act rd %0d unit %0d addr %0h failed %0d last %0d",
                 act.rd, act.unit, act.addr, act.failed, act.last);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, in_opcode, in_is_read;
  logic [TAG_W-1:0]  in_request_tag;
  logic [BLK_W-1:0]  in_start_block;
  logic [CNT_W-1:0]  in_block_count;
  logic [UNIT_W-1:0] in_unit;
  logic [ADDR_W-1:0] in_buffer_address;
  logic [ERR_W-1:0]  in_err_code;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CHUNK_W-1:0]   cfg_data;
  logic out_valid, out_ready, out_cmd_read, out_failed, out_last;
  logic [KIND_W-1:0]  out_kind;
  logic [TAG_W-1:0]   out_out_tag;
  logic [BLK_W-1:0]   out_cmd_block;
  logic [CHUNK_W-1:0] out_cmd_count;
  logic [UNIT_W-1:0]  out_cmd_unit;
  logic [ADDR_W-1:0]  out_cmd_address;

  elevator_scoreboard sb = new();
  bit no_idle;
  bit hold_sink;
  int inserts, completions;

  disk_elevator_request_scheduler i_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Result sink: random stalls, a long hold-off on request.
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_ready = 0;
        repeat (400) @(negedge clk);
        hold_sink = 0;
      end
      out_ready = no_idle ? 1'b1 : ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin
    sched_result_t act;
    if (rst_n && out_valid && out_ready) begin
      act.kind = kind_t'(out_kind); act.tag = out_out_tag; act.blk = out_cmd_block;
      act.cnt = out_cmd_count; act.rd = out_cmd_read; act.unit = out_cmd_unit;
      act.addr = out_cmd_address; act.failed = out_failed; act.last = out_last;
      sb.check_result(act);
    end
  end

  task automatic send_beat(logic opc, logic [TAG_W-1:0] tag, logic [BLK_W-1:0] blk,
                           logic [CNT_W-1:0] cnt, logic rd, logic [UNIT_W-1:0] unit,
                           logic [ADDR_W-1:0] addr, logic [ERR_W-1:0] err);
    in_valid = 1; in_opcode = opc; in_request_tag = tag; in_start_block = blk;
    in_block_count = cnt; in_is_read = rd; in_unit = unit; in_buffer_address = addr;
    in_err_code = err;
    do @(posedge clk); while (!in_ready);
    sb.accept_request(opc, tag, blk, cnt, rd, unit, addr, err);
    if (opc == OPC_INSERT) inserts++;
    else completions++;
    @(negedge clk);
    if (!no_idle && $urandom_range(99) < 26) begin
      in_valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic insert_req(logic [TAG_W-1:0] tag, logic [BLK_W-1:0] blk,
                            logic [CNT_W-1:0] cnt, logic [ADDR_W-1:0] addr);
    send_beat(OPC_INSERT, tag, blk, cnt, 1'($urandom_range(1)),
              UNIT_W'($urandom_range(7)), addr, ERR_W'($urandom));
  endtask

  task automatic complete_req(logic [ERR_W-1:0] err);
    send_beat(OPC_COMPLETE, TAG_W'($urandom), BLK_W'($urandom), CNT_W'($urandom),
              1'($urandom_range(1)), UNIT_W'($urandom_range(7)), ADDR_W'($urandom), err);
  endtask

  // Waits until every expected beat is out, then for insert beats still in flight.
  task automatic drain();
    in_valid = 0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CHUNK_W-1:0] data);
    cfg_valid = 1; cfg_index = idx; cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic random_traffic(int n);
    logic [CNT_W-1:0] cnt;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if ((sb.busy && sel < 55) || (!sb.busy && sel < 3)) begin
        complete_req(($urandom_range(99) < 80) ? 7'd0 : ERR_W'($urandom_range(1, 127)));
      end else begin
        sel = $urandom_range(99);
        cnt = (sel < 70) ? CNT_W'($urandom_range(40)) :
              (sel < 95) ? CNT_W'($urandom_range(600)) : CNT_W'($urandom);
        // narrow block ranges give equal block numbers now and then
        insert_req(TAG_W'($urandom),
                   ($urandom_range(3) == 0) ? BLK_W'($urandom_range(7)) : BLK_W'($urandom),
                   cnt, ADDR_W'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_opcode = 0; in_request_tag = 0; in_start_block = 0;
    in_block_count = 0; in_is_read = 0; in_unit = 0; in_buffer_address = 0;
    in_err_code = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    no_idle = 0; hold_sink = 0;
    repeat (6) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: idle completion, fill past full, extremes, retry and success
    complete_req(7'd0);
    send_beat(OPC_INSERT, 8'hFF, 21'h1FFFFF, 16'd600, 1'b1, 3'd7, 24'hFFFFFF, 7'h7F);
    send_beat(OPC_INSERT, 8'h00, 21'd0, 16'd0, 1'b0, 3'd0, 24'd0, 7'd0);
    for (int i = 0; i < 15; i++)
      insert_req(TAG_W'(i + 1), BLK_W'(100 * (i % 4)), CNT_W'(i), ADDR_W'($urandom));
    insert_req(8'hAA, 21'd5, 16'hFFFF, 24'h123456);
    complete_req(7'd0);
    complete_req(7'd0);
    complete_req(7'h7F);
    complete_req(7'd1);
    complete_req(7'd2);
    drain();

    write_cfg(CFG_RETRY_LIMIT, 9'd1);
    write_cfg(CFG_MAX_CHUNK, 9'd1);
    random_traffic(250);
    drain();

    write_cfg(CFG_RETRY_LIMIT, 9'd15);
    write_cfg(CFG_MAX_CHUNK, 9'h1FF);
    no_idle = 1;
    random_traffic(200);
    no_idle = 0;
    hold_sink = 1;
    random_traffic(250);
    drain();

    write_cfg(CFG_RETRY_LIMIT, 9'd0);
    write_cfg(CFG_MAX_CHUNK, 9'd0);
    random_traffic(250);
    drain();

    write_cfg(CFG_RETRY_LIMIT, 9'h1F7);
    write_cfg(CFG_MAX_CHUNK, 9'd256);
    random_traffic(250);
    drain();

    write_cfg(CFG_RETRY_LIMIT, 9'd3);
    write_cfg(CFG_MAX_CHUNK, 9'd37);
    random_traffic(230);
    drain();

    $display("Sent %0d inserts and %0d completions over six register settings.",
             inserts, completions);
    $display("Checked %0d result beats: %0d rejects, %0d unexpected, %0d failed requests.",
             sb.checked, sb.rejects, sb.unexpected, sb.failures);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
